// ----- rtl/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/pwsp_pkg.sv -----
package pwsp_pkg;

	localparam logic [15:0] FILL_WORD = 16'h0aaa;

	// word code in bits 14..13, side in bit 15
	localparam logic [1:0] CODE_X = 2'b01;
	localparam logic [1:0] CODE_Y = 2'b10;
	localparam logic [1:0] CODE_P = 2'b11;

	localparam int DataW = 13;
	localparam int CmdDepth = 2;

	// commands from the front to the back
	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_GAP     = 2'd1;
	localparam logic [1:0] OP_PAYLOAD = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

// ----- rtl/pwsp_word_if.sv -----
interface pwsp_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] word;
	logic        packet_start;
	logic        restart;

	modport source (output valid, output word, output packet_start, output restart,
		input ready);
	modport sink (input valid, input word, input packet_start, input restart,
		output ready);
endinterface

// ----- rtl/pwsp_result_if.sv -----
interface pwsp_result_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [12:0]        x_pos;
	logic [12:0]        y_pos;
	logic [12:0]        pulse_height;
	logic signed [15:0] gap;
	logic [31:0]        reject_count;

	modport source (output valid, output kind, output x_pos, output y_pos,
		output pulse_height, output gap, output reject_count, input ready);
	modport sink (input valid, input kind, input x_pos, input y_pos,
		input pulse_height, input gap, input reject_count, output ready);
endinterface

// ----- rtl/pwsp_front.sv -----
module pwsp_front #(
	parameter int HEADER_WORDS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pwsp_word_if.sink             words,
	input  pwsp_pkg::fifo_status_t fifo_status,
	output logic                  push,
	output pwsp_pkg::cmd_t        cmd
);
	import pwsp_pkg::*;

	localparam int PosW = (HEADER_WORDS > 1) ? $clog2(HEADER_WORDS) : 1;

	logic [PosW-1:0] pos_q;
	logic [15:0]     expected_q;
	logic            accept;
	logic [15:0]     diff;

	assign words.ready = !fifo_status.full;
	assign accept = words.valid && words.ready;
	assign diff = words.word - expected_q;

	always_comb begin
		push = 1'b0;
		cmd.op = OP_PAYLOAD;
		cmd.data = words.word;
		if (accept) begin
			if (words.restart) begin
				push = 1'b1;
				cmd.op = OP_RESTART;
			end else if (words.packet_start) begin
				push = (diff != 16'd0);
				cmd.op = OP_GAP;
				cmd.data = diff;
			end else if (pos_q == '0) begin
				// null words in payload are dropped here
				push = (words.word != FILL_WORD);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			expected_q <= '0;
		end else if (accept && !words.restart) begin
			if (words.packet_start) begin
				expected_q <= words.word + 16'd1;
				pos_q <= PosW'(HEADER_WORDS - 1);
			end else if (pos_q != '0) begin
				pos_q <= pos_q - PosW'(1);
			end
		end
	end

endmodule

// ----- rtl/pwsp_cmd_fifo.sv -----
module pwsp_cmd_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pwsp_pkg::cmd_t         wr_cmd,
	input  logic                   pop,
	output pwsp_pkg::cmd_t         rd_cmd,
	output pwsp_pkg::fifo_status_t status
);
	import pwsp_pkg::*;

	localparam int PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
	localparam int CntW = $clog2(CmdDepth + 1);

	cmd_t            mem_q [CmdDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign rd_cmd = mem_q[rd_ptr_q];
	assign status.full = (count_q == CntW'(CmdDepth));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ----- rtl/pwsp_back.sv -----
module pwsp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pwsp_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           pop,
	pwsp_result_if.source  results
);
	import pwsp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LY   = 3'd1;
	localparam logic [2:0] ST_LP   = 3'd2;
	localparam logic [2:0] ST_RY   = 3'd3;
	localparam logic [2:0] ST_RP   = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [DataW-1:0] held_x_q;
	logic [DataW-1:0] held_y_q;
	logic [31:0]      bad_q;
	logic             out_valid_q;
	logic             kind_q;
	logic [DataW-1:0] x_q;
	logic [DataW-1:0] y_q;
	logic [DataW-1:0] p_q;
	logic [15:0]      gap_q;
	logic [31:0]      bad_out_q;

	logic             side;
	logic [1:0]       code;
	logic [DataW-1:0] data;
	logic             count_bad;
	logic             load_x;
	logic             load_y;
	logic             emit_photon;
	logic             emit_gap;
	logic             emit_now;

	assign pop = cmd_valid && (!out_valid_q || results.ready);
	assign side = cmd.data[15];
	assign code = cmd.data[14:13];
	assign data = cmd.data[DataW-1:0];

	always_comb begin
		state_d = state_q;
		count_bad = 1'b0;
		load_x = 1'b0;
		load_y = 1'b0;
		emit_photon = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (code == CODE_X) begin
					load_x = 1'b1;
					state_d = side ? ST_RY : ST_LY;
				end else begin
					count_bad = 1'b1;
				end
			end
			ST_LY, ST_RY: begin
				if (code == CODE_Y && side == (state_q == ST_RY)) begin
					load_y = 1'b1;
					state_d = (state_q == ST_RY) ? ST_RP : ST_LP;
				end else begin
					count_bad = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_LP, ST_RP: begin
				state_d = ST_IDLE;
				if (code == CODE_P && side == (state_q == ST_RP)) begin
					emit_photon = 1'b1;
				end else begin
					count_bad = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign emit_gap = (cmd.op == OP_GAP);
	assign emit_now = pop && (emit_gap || (cmd.op == OP_PAYLOAD && emit_photon));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_x_q <= '0;
			held_y_q <= '0;
			bad_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (cmd.op)
					OP_RESTART: begin
						state_q <= ST_IDLE;
						held_x_q <= '0;
						held_y_q <= '0;
						bad_q <= '0;
					end
					OP_PAYLOAD: begin
						state_q <= state_d;
						if (load_x) held_x_q <= data;
						if (load_y) held_y_q <= data;
						if (count_bad && bad_q != '1) bad_q <= bad_q + 32'd1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (emit_now) begin
			kind_q <= emit_gap;
			x_q <= emit_gap ? '0 : held_x_q;
			y_q <= emit_gap ? '0 : held_y_q;
			p_q <= emit_gap ? '0 : data;
			gap_q <= emit_gap ? cmd.data : 16'd0;
			bad_out_q <= bad_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.kind = kind_q;
	assign results.x_pos = x_q;
	assign results.y_pos = y_q;
	assign results.pulse_height = p_q;
	assign results.gap = $signed(gap_q);
	assign results.reject_count = bad_out_q;

endmodule

// ----- rtl/photon_word_stream_parser_core.sv -----
// photon word stream parser
// words: one 16-bit detector packet word per item, with packet_start marking
//   the packet number word and restart clearing the parser and bad count
// results: photon events (kind 0) and packet number gap reports (kind 1),
//   each carrying the bad word count at that point
// the front checks packet numbers and skips header and null words, then
// queues commands in a two-entry queue; the back runs the x/y/p parser
// and owns the registered result stage
// throughput: one word per cycle, limited only by the result register
// path: a word's command is written to the queue at the edge that accepts
//   the word; the back pops it from the queue head, parses it and loads the
//   result register when that register is empty or being taken
// a stall on results fills the result register, then the queue; words.ready
//   drops once the queue is full and rises right after the edge that pops it
// reset: asynchronous, clears parser state, expected packet number, header
//   position, bad count, queue and result valid; no clearing pass
module photon_word_stream_parser_core #(
	parameter int HEADER_WORDS = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	pwsp_word_if.sink     words,
	pwsp_result_if.source results
);
	import pwsp_pkg::*;

	`include "assert_macros.svh"

	logic         push;
	logic         pop;
	cmd_t         wr_cmd;
	cmd_t         rd_cmd;
	fifo_status_t fifo_status;

	pwsp_front #(
		.HEADER_WORDS(HEADER_WORDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.words      (words),
		.fifo_status(fifo_status),
		.push       (push),
		.cmd        (wr_cmd)
	);

	pwsp_cmd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(wr_cmd),
		.pop   (pop),
		.rd_cmd(rd_cmd),
		.status(fifo_status)
	);

	pwsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (rd_cmd),
		.cmd_valid(!fifo_status.empty),
		.pop      (pop),
		.results  (results)
	);

	`ASSERT_ALWAYS(a_fifo_flags, clk, arst_n, !(fifo_status.full && fifo_status.empty),
		"queue full and empty at once")
	`ASSERT_IMPLY(a_gap_from_start, clk, arst_n, push && wr_cmd.op == OP_GAP,
		words.valid && words.ready && words.packet_start && !words.restart,
		"gap command without packet start")
	`ASSERT_IMPLY(a_result_from_pop, clk, arst_n, $rose(results.valid), $past(pop),
		"result without a queue pop")
	`ASSERT_NEXT(a_no_pop_empty, clk, arst_n, fifo_status.empty && !push, !pop,
		"pop from empty queue")

endmodule

// ----- bench/pwsp_event_predictor.sv -----
`timescale 1ns / 1ps

module pwsp_event_predictor #(
	parameter int HEADER_WORDS = 3
) (
	input  logic   clk,
	input  logic   arst_n,
	pwsp_word_if   words,
	pwsp_result_if results,
	output int     mismatches,
	output int     outstanding
);
	import pwsp_pkg::*;

	typedef enum logic [2:0] {
		PS_IDLE    = 3'd0,
		PS_LEFT_Y  = 3'd1,
		PS_LEFT_P  = 3'd2,
		PS_RIGHT_Y = 3'd3,
		PS_RIGHT_P = 3'd4
	} parse_state_e;

	typedef struct {
		logic               kind;
		logic [12:0]        x_pos;
		logic [12:0]        y_pos;
		logic [12:0]        pulse_height;
		logic signed [15:0] gap;
		logic [31:0]        reject_count;
	} photon_result_t;

	parse_state_e   parse_st;
	logic [12:0]    held_x;
	logic [12:0]    held_y;
	logic [1:0]     headers_left;
	logic [15:0]    next_packet;
	logic [31:0]    bad_total;
	photon_result_t expected_results[$];
	photon_result_t oldest;
	int             fail_count;

	function automatic void count_bad_word();
		if (bad_total != 32'hffff_ffff)
			bad_total++;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// advances the parser copy by one word and queues the result it causes
	function automatic void predict_word(logic [15:0] w, logic start, logic clear);
		photon_result_t r;
		logic           side;
		logic [1:0]     code;
		logic [12:0]    data;
		side = w[15];
		code = w[14:13];
		data = w[12:0];
		r = '{default: '0};
		if (clear) begin
			parse_st = PS_IDLE;
			held_x = '0;
			held_y = '0;
			bad_total = '0;
			return;
		end
		if (start) begin
			if (w != next_packet) begin
				r.kind = 1'b1;
				r.gap = w - next_packet;
				r.reject_count = bad_total;
				expected_results.push_back(r);
			end
			next_packet = w + 16'd1;
			headers_left = 2'(HEADER_WORDS - 1);
			return;
		end
		if (headers_left != 0) begin
			headers_left--;
			return;
		end
		if (w == FILL_WORD)
			return;
		case (parse_st)
			PS_IDLE: begin
				if (code == CODE_X) begin
					held_x = data;
					parse_st = side ? PS_RIGHT_Y : PS_LEFT_Y;
				end else begin
					count_bad_word();
				end
			end
			PS_LEFT_Y, PS_RIGHT_Y: begin
				if (code == CODE_Y && side == (parse_st == PS_RIGHT_Y)) begin
					held_y = data;
					parse_st = side ? PS_RIGHT_P : PS_LEFT_P;
				end else begin
					count_bad_word();
					parse_st = PS_IDLE;
				end
			end
			PS_LEFT_P, PS_RIGHT_P: begin
				if (code == CODE_P && side == (parse_st == PS_RIGHT_P)) begin
					r.x_pos = held_x;
					r.y_pos = held_y;
					r.pulse_height = data;
					r.reject_count = bad_total;
					expected_results.push_back(r);
				end else begin
					count_bad_word();
				end
				parse_st = PS_IDLE;
			end
			default: parse_st = PS_IDLE;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_st = PS_IDLE;
			held_x = '0;
			held_y = '0;
			headers_left = '0;
			next_packet = '0;
			bad_total = '0;
			fail_count = 0;
			expected_results.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected, kind %0d gap %0d reject_count %0d",
						$time, results.kind, results.gap, results.reject_count);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("kind", 32'(oldest.kind), 32'(results.kind));
					check_field("x_pos", 32'(oldest.x_pos), 32'(results.x_pos));
					check_field("y_pos", 32'(oldest.y_pos), 32'(results.y_pos));
					check_field("pulse_height", 32'(oldest.pulse_height),
						32'(results.pulse_height));
					check_field("gap", 32'(oldest.gap), 32'(results.gap));
					check_field("reject_count", oldest.reject_count, results.reject_count);
				end
			end
			if (words.valid && words.ready)
				predict_word(words.word, words.packet_start, words.restart);
			outstanding <= expected_results.size();
			mismatches <= fail_count;
		end
	end

endmodule

// ----- bench/photon_word_stream_parser_core_test.sv -----
`timescale 1ns / 1ps

module photon_word_stream_parser_core_test;
	import pwsp_pkg::*;

	localparam int HEADER_WORDS = 3;
	localparam int RANDOM_WORDS = 415;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic [15:0] word;
		logic        start;
		logic        clear;
	} word_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	int         mismatches;
	int         outstanding;
	int         words_taken = 0;
	int         idle_cycles = 0;
	word_item_t word_plan[$];
	logic [15:0] packet_counter = '0;

	pwsp_word_if   word_ch ();
	pwsp_result_if result_ch ();

	photon_word_stream_parser_core #(
		.HEADER_WORDS(HEADER_WORDS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (word_ch),
		.results(result_ch)
	);

	pwsp_event_predictor #(
		.HEADER_WORDS(HEADER_WORDS)
	) event_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.words      (word_ch),
		.results    (result_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// queues one word item and keeps the packet number that the next in-order packet should carry
	function automatic void plan_word(logic [15:0] w, logic start, logic clear);
		word_item_t it;
		it.word = w;
		it.start = start;
		it.clear = clear;
		word_plan.push_back(it);
		if (start && !clear)
			packet_counter = w + 16'd1;
	endfunction

	initial begin
		word_item_t  it;
		int          directed_count;
		int          burst;
		int          pause;
		logic        side;
		logic [1:0]  photon_codes [3];
		photon_codes = '{CODE_X, CODE_Y, CODE_P};
		word_ch.valid <= 1'b0;
		word_ch.word <= '0;
		word_ch.packet_start <= 1'b0;
		word_ch.restart <= 1'b0;

		// payload before any packet start, then idle junk
		plan_word(16'h3fff, 1'b0, 1'b0);
		plan_word(16'h4000, 1'b0, 1'b0);
		plan_word(16'h6abc, 1'b0, 1'b0);
		plan_word(16'h0000, 1'b0, 1'b0);
		// in-order packet, null word as a header word
		plan_word(16'h0000, 1'b1, 1'b0);
		plan_word(FILL_WORD, 1'b0, 1'b0);
		plan_word(16'h2345, 1'b0, 1'b0);
		// right side photon with a null word in the middle
		plan_word(16'ha000, 1'b0, 1'b0);
		plan_word(FILL_WORD, 1'b0, 1'b0);
		plan_word(16'hdfff, 1'b0, 1'b0);
		plan_word(16'he000, 1'b0, 1'b0);
		// wrong code while waiting for y, wrong side, wrong code while waiting for p
		plan_word(16'h2001, 1'b0, 1'b0);
		plan_word(16'h6002, 1'b0, 1'b0);
		plan_word(16'ha005, 1'b0, 1'b0);
		plan_word(16'h4006, 1'b0, 1'b0);
		plan_word(16'h2007, 1'b0, 1'b0);
		plan_word(16'h4008, 1'b0, 1'b0);
		plan_word(16'h2009, 1'b0, 1'b0);
		// new packet mid photon, null word as packet number, parser state carries over
		plan_word(16'h2010, 1'b0, 1'b0);
		plan_word(16'h4011, 1'b0, 1'b0);
		plan_word(FILL_WORD, 1'b1, 1'b0);
		plan_word(16'h1111, 1'b0, 1'b0);
		plan_word(16'h2222, 1'b0, 1'b0);
		plan_word(16'h6012, 1'b0, 1'b0);
		// most negative and most positive gaps, starts inside the header, wrap to zero
		plan_word(16'h8aab, 1'b1, 1'b0);
		plan_word(16'h0aab, 1'b1, 1'b0);
		plan_word(16'hffff, 1'b1, 1'b0);
		plan_word(16'h0000, 1'b1, 1'b0);
		plan_word(16'hffff, 1'b0, 1'b0);
		plan_word(16'h0000, 1'b0, 1'b0);
		// restart in the middle of a photon
		plan_word(16'h2100, 1'b0, 1'b0);
		plan_word(16'hffff, 1'b1, 1'b1);
		plan_word(16'h4000, 1'b0, 1'b0);
		directed_count = word_plan.size();

		while (word_plan.size() < directed_count + RANDOM_WORDS) begin
			if ($urandom_range(0, 29) == 0)
				plan_word(16'($urandom), 1'($urandom_range(0, 1)), 1'b1);
			plan_word(($urandom_range(0, 7) == 0) ? 16'($urandom) : packet_counter,
				1'b1, 1'b0);
			repeat (HEADER_WORDS - 1)
				plan_word(16'($urandom), 1'b0, 1'b0);
			repeat ($urandom_range(0, 8)) begin
				side = 1'($urandom_range(0, 1));
				foreach (photon_codes[i]) begin
					if ($urandom_range(0, 11) == 0)
						plan_word(FILL_WORD, 1'b0, 1'b0);
					if ($urandom_range(0, 14) == 0)
						plan_word(16'($urandom), 1'b0, 1'b0);
					else
						plan_word({side, photon_codes[i], 13'($urandom)}, 1'b0, 1'b0);
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (word_plan.size() != 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && word_plan.size() != 0) begin
				it = word_plan.pop_front();
				word_ch.valid <= 1'b1;
				word_ch.word <= it.word;
				word_ch.packet_start <= it.start;
				word_ch.restart <= it.clear;
				@(posedge clk);
				while (!word_ch.ready)
					@(posedge clk);
				burst--;
			end
			pause = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (pause != 0) begin
				word_ch.valid <= 1'b0;
				repeat (pause) @(posedge clk);
			end
		end
		word_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: random stall patterns, plus two long holds while words keep coming
	initial begin
		int mode;
		int seg;
		int holds_done;
		holds_done = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if ((holds_done == 0 && words_taken >= 60) ||
				(holds_done == 1 && words_taken >= 300)) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			mode = $urandom_range(0, 3);
			seg = $urandom_range(8, 40);
			repeat (seg) begin
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (word_ch.valid && word_ch.ready)
				words_taken <= words_taken + 1;
			if ((word_ch.valid && word_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
